[hdl/biquad_cascade_filter_bank_unit_assert.svh]
// Assertion macros for the filter bank.
`ifndef BIQUAD_CASCADE_FILTER_BANK_UNIT_ASSERT_SVH
`define BIQUAD_CASCADE_FILTER_BANK_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BCFB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bcfb assertion failed");
`define BCFB_ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bcfb assertion failed");
`else
`define BCFB_ASSERT(lbl, clk, rst_n, prop)
`define BCFB_ASSERT_CLK(lbl, clk, prop)
`endif
`endif

[hdl/bcfb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bcfb_pkg;
  localparam int MAX_FILTERS  = 8;
  localparam int MAX_SECTIONS = 4;
  localparam int COEFS        = 6;
  localparam int FW  = $clog2(MAX_FILTERS);
  localparam int SW  = $clog2(MAX_SECTIONS);
  localparam int CAW = $clog2(MAX_FILTERS * MAX_SECTIONS * COEFS);
  localparam int CDEPTH = MAX_FILTERS * MAX_SECTIONS * COEFS;
  localparam int DAW = FW + SW + 1;
  localparam int DDEPTH = MAX_FILTERS * MAX_SECTIONS * 2;
  localparam logic [3:0] MAXF4 = 4'(MAX_FILTERS);
  localparam logic [2:0] MAXS3 = 3'(MAX_SECTIONS);
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  localparam logic [2:0] C_B0 = 3'd0;
  localparam logic [2:0] C_B1 = 3'd1;
  localparam logic [2:0] C_B2 = 3'd2;
  localparam logic [2:0] C_A1 = 3'd4;
  localparam logic [2:0] C_A2 = 3'd5;
  localparam logic [2:0] C_LIMIT = 3'(COEFS);

  localparam logic [7:0] REG_FILTER_COUNT  = 8'd0;
  localparam logic [7:0] REG_SECTION_COUNT = 8'd1;

  typedef enum logic [1:0] {ST_IDLE, ST_START, ST_STEP, ST_EMIT} state_e;

  typedef enum logic [2:0] {
    STP_ISSUE, STP_A1W1, STP_A2W2, STP_B1W1, STP_W0, STP_B2W2, STP_B0W0, STP_Y
  } step_e;

  typedef struct packed {
    logic          load_x;
    logic          start;
    logic          step_en;
    step_e         step;
    logic [FW-1:0] filt;
    logic [SW-1:0] sect;
    logic          emit;
    logic          last;
    logic          coef_wr;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;
endpackage
`default_nettype wire

[hdl/bcfb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module bcfb_ctrl
  import bcfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_func_i,
  output logic       in_ready_o,
  input  logic       cfg_valid_i,
  input  logic [7:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);
  state_e        state_q, state_d;
  step_e         step_q, step_d;
  logic [FW-1:0] f_q, f_d;
  logic [SW-1:0] s_q, s_d;
  logic [3:0]    fc_q;
  logic [2:0]    sc_q;
  logic [3:0]    nf;
  logic [2:0]    ns;
  logic          accept, last_f, last_s;

  assign nf     = (fc_q > MAXF4) ? MAXF4 : fc_q;
  assign ns     = (sc_q > MAXS3) ? MAXS3 : sc_q;
  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign last_f = (4'({1'b0, f_q}) + 4'd1) == nf;
  assign last_s = (3'({1'b0, s_q}) + 3'd1) == ns;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= MAXF4;
      sc_q <= MAXS3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FILTER_COUNT:  fc_q <= cfg_data_i[3:0];
        REG_SECTION_COUNT: sc_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    f_d     = f_q;
    s_d     = s_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !in_func_i && nf != 4'd0) begin
          f_d     = '0;
          state_d = ST_START;
        end
      end
      ST_START: begin
        s_d     = '0;
        step_d  = STP_ISSUE;
        state_d = (ns == 3'd0) ? ST_EMIT : ST_STEP;
      end
      ST_STEP: begin
        step_d = step_e'(3'(step_q) + 3'd1);
        if (step_q == STP_Y) begin
          if (last_s) state_d = ST_EMIT;
          else s_d = s_q + SW'(1);
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          if (last_f) state_d = ST_IDLE;
          else begin
            f_d     = f_q + FW'(1);
            state_d = ST_START;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    cmd_o.load_x  = accept && !in_func_i;
    cmd_o.coef_wr = accept && in_func_i;
    cmd_o.start   = (state_q == ST_START);
    cmd_o.step_en = (state_q == ST_STEP);
    cmd_o.step    = step_q;
    cmd_o.filt    = f_q;
    cmd_o.sect    = s_q;
    cmd_o.emit    = (state_q == ST_EMIT) && stat_i.out_free;
    cmd_o.last    = last_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STP_ISSUE;
      f_q     <= '0;
      s_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      f_q     <= f_d;
      s_q     <= s_d;
    end
  end
endmodule
`default_nettype wire

[hdl/bcfb_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
module bcfb_datapath
  import bcfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic [63:0] in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_data_o,
  output logic        out_last_o
);
  logic signed [31:0] coef_mem [CDEPTH];
  logic signed [31:0] dly_mem  [DDEPTH];
  logic [CDEPTH-1:0]  coef_vld_q;
  logic [DDEPTH-1:0]  dly_vld_q;

  logic signed [23:0] x_q, y_q, out_y_q;
  logic signed [31:0] w1_q, w2_q, w0_q, coef_mem_q, dly_mem_q;
  logic               coef_hit_q, coef_one_q, dly_hit_q;
  logic signed [63:0] acc_q, prod_q;
  logic               out_vld_q, out_last_q;
  logic [FW-1:0]      out_bank_q;

  logic [FW-1:0]      wr_f;
  logic [SW-1:0]      wr_s;
  logic [2:0]         wr_c, rd_c;
  logic [CAW-1:0]     wr_caddr, rd_caddr;
  logic [DAW-1:0]     rd_daddr, wr_daddr;
  logic               dly_we;
  logic signed [31:0] dly_wdata, coef_rd, dly_rd, op_b;
  logic signed [63:0] mul, term, rnd;
  logic signed [31:0] w0_sat;
  logic signed [23:0] y_sat;

  assign wr_f = in_data_i[24 +: FW];
  assign wr_s = in_data_i[27 +: SW];
  assign wr_c = in_data_i[31:29];
  assign wr_caddr = CAW'({wr_f, wr_s}) * CAW'(COEFS) + CAW'(wr_c);
  assign rd_caddr = CAW'({cmd_i.filt, cmd_i.sect}) * CAW'(COEFS) + CAW'(rd_c);

  // Coefficient fetched one step ahead of the step that multiplies with it.
  always_comb begin
    case (cmd_i.step)
      STP_ISSUE: rd_c = C_A1;
      STP_A1W1:  rd_c = C_A2;
      STP_A2W2:  rd_c = C_B1;
      STP_B1W1:  rd_c = C_B2;
      default:   rd_c = C_B0;
    endcase
  end

  assign rd_daddr  = {cmd_i.filt, cmd_i.sect, (cmd_i.step != STP_ISSUE)};
  assign dly_we    = cmd_i.step_en &&
                     (cmd_i.step == STP_W0 || cmd_i.step == STP_B2W2);
  assign wr_daddr  = {cmd_i.filt, cmd_i.sect, (cmd_i.step == STP_W0)};
  assign dly_wdata = (cmd_i.step == STP_W0) ? w1_q : w0_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_wr && wr_c < C_LIMIT) coef_mem[wr_caddr] <= in_data_i[63:32];
    coef_mem_q <= coef_mem[rd_caddr];
    if (dly_we) dly_mem[wr_daddr] <= dly_wdata;
    dly_mem_q <= dly_mem[rd_daddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      dly_vld_q  <= '0;
      coef_hit_q <= 1'b0;
      coef_one_q <= 1'b0;
      dly_hit_q  <= 1'b0;
    end else begin
      if (cmd_i.coef_wr && wr_c < C_LIMIT) coef_vld_q[wr_caddr] <= 1'b1;
      if (dly_we) dly_vld_q[wr_daddr] <= 1'b1;
      coef_hit_q <= coef_vld_q[rd_caddr];
      coef_one_q <= (rd_c == C_B0);
      dly_hit_q  <= dly_vld_q[rd_daddr];
    end
  end

  // Entries never written read as the pass-through reset values.
  assign coef_rd = coef_hit_q ? coef_mem_q : (coef_one_q ? ONE_Q30 : 32'sd0);
  assign dly_rd  = dly_hit_q ? dly_mem_q : 32'sd0;

  always_comb begin
    case (cmd_i.step)
      STP_A1W1, STP_A2W2: op_b = dly_rd;
      STP_B1W1:           op_b = w1_q;
      STP_W0:             op_b = w2_q;
      default:            op_b = w0_q;
    endcase
  end

  assign mul  = coef_rd * op_b;
  assign term = prod_q >>> 2;
  assign rnd  = (acc_q + 64'sd134217728) >>> 28;

  always_comb begin
    if (rnd > 64'sd2147483647)       w0_sat = 32'sh7fff_ffff;
    else if (rnd < -64'sd2147483648) w0_sat = 32'sh8000_0000;
    else                             w0_sat = rnd[31:0];
    if (rnd > 64'sd8388607)          y_sat = 24'sh7f_ffff;
    else if (rnd < -64'sd8388608)    y_sat = 24'sh80_0000;
    else                             y_sat = rnd[23:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) x_q <= in_data_i[23:0];
    if (cmd_i.start) y_q <= x_q;
    prod_q <= mul;
    if (cmd_i.step_en) begin
      case (cmd_i.step)
        STP_ISSUE: acc_q <= 64'(y_q) <<< 28;
        STP_A1W1:  w1_q <= dly_rd;
        STP_A2W2: begin
          acc_q <= acc_q - term;
          w2_q  <= dly_rd;
        end
        STP_B1W1:  acc_q <= acc_q - term;
        STP_W0: begin
          w0_q  <= w0_sat;
          acc_q <= term;
        end
        STP_B2W2, STP_B0W0: acc_q <= acc_q + term;
        default:   y_q <= y_sat;
      endcase
    end
    if (cmd_i.emit) begin
      out_bank_q <= cmd_i.filt;
      out_y_q    <= y_q;
      out_last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (cmd_i.emit) out_vld_q <= 1'b1;
    else if (out_ready_i) out_vld_q <= 1'b0;
  end

  assign stat_o.out_free = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = {5'd0, out_y_q, out_bank_q};
  assign out_last_o  = out_last_q;
endmodule
`default_nettype wire

[hdl/biquad_cascade_filter_bank_unit.sv]
// Channel   Dir  Payload
// s_axis    in   tdata: sample, filter_index, section_index, coef_index, coef_value
//                tuser: func
// m_axis    out  tdata: bank_index, filtered; tlast: last
// cfg       in   cfg_index_i, cfg_data_i
// A coefficient write is taken only while idle. A sample runs through each
// active filter in steps set by the single shared multiplier and one coefficient
// memory read per step. Results wait in one output register; a stalled result
// holds the sequencer only when the next filter is ready to emit. Reset restores
// pass-through coefficients and zero delays through valid bits.
`timescale 1ns / 1ps
`default_nettype none
`include "biquad_cascade_filter_bank_unit_assert.svh"
module biquad_cascade_filter_bank_unit
  import bcfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [23:0] sample, [26:24] filter_index, [28:27] section_index,
  // [31:29] coef_index, [63:32] coef_value
  input  logic [63:0] s_axis_tdata,
  // [0] func
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] bank_index, [26:3] filtered, rest zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  bcfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_func_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bcfb_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // A new result is loaded only into a free output register.
  `BCFB_ASSERT(a_emit_free, clk_i, rst_ni, cmd.emit |-> stat.out_free)
  // Coefficient writes only happen while the sequencer is idle.
  `BCFB_ASSERT(a_wr_idle, clk_i, rst_ni, cmd.coef_wr |-> s_axis_tready)
  // The output side turns valid only after the sequencer emitted.
  `BCFB_ASSERT(a_out_src, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(cmd.emit))
  // The sequencer never runs a section while an input is being taken.
  `BCFB_ASSERT(a_no_overlap, clk_i, rst_ni, cmd.step_en |-> !s_axis_tready)
endmodule
`default_nettype wire
